### sv/dcm_pkg.sv
// shared types, codes and constants of the door clutch and motor sequencer
`default_nettype none

package dcm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int POS_BITS        = 12;
    localparam int ANGLE_BITS      = 9;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 8;
    localparam int IN_DATA_BITS    = 16;
    localparam int OUT_DATA_BITS   = 40;

    localparam logic [11:0] SERVO_STOP     = 12'd1500;
    localparam logic [11:0] SERVO_SWING    = 12'd1000;
    localparam logic [7:0]  DUTY_STOP      = 8'd255;
    localparam logic [7:0]  DUTY_FULL_SET  = 8'd255;
    localparam logic [7:0]  DUTY_SLOW_SET  = 8'd170;
    localparam logic [8:0]  ANGLE_SPAN     = 9'd270;
    localparam logic [7:0]  OPEN_ANGLE_RST  = 8'd238;
    localparam logic [7:0]  CLOSE_ANGLE_RST = 8'd118;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OPEN_ANGLE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLOSE_ANGLE = 1'd1;

    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    // clutch sequencer phases
    localparam logic [1:0] CL_IDLE  = 2'd0;
    localparam logic [1:0] CL_START = 2'd1;
    localparam logic [1:0] CL_WAIT  = 2'd2;

    // door sequencer phases
    localparam logic [2:0] DR_IDLE   = 3'd0;
    localparam logic [2:0] DR_START  = 3'd1;
    localparam logic [2:0] DR_ENGAGE = 3'd2;
    localparam logic [2:0] DR_DRIVE  = 3'd3;
    localparam logic [2:0] DR_STOP   = 3'd4;

    localparam logic [1:0] DOOR_UNKNOWN = 2'd0;
    localparam logic [1:0] DOOR_OPENED  = 2'd1;
    localparam logic [1:0] DOOR_CLOSED  = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_ENGAGE    = 3'd1,
        CMD_DISENGAGE = 3'd2,
        CMD_OPEN      = 3'd3,
        CMD_CLOSE     = 3'd4,
        CMD_STARTUP   = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t        pending;
        logic [1:0]  engage_phase;
        logic [1:0]  disengage_phase;
        logic [2:0]  open_phase;
        logic [2:0]  close_phase;
        logic        clutch;
        logic [1:0]  door;
        logic        busy;
        logic [11:0] servo;
        logic [7:0]  duty;
        logic        dir;
    } seq_state_t;

    // packed from the top bit down, so the sample lands in the low bits
    typedef struct packed {
        logic [1:0]          mode;
        logic                engaged_switch;
        logic                disengaged_switch;
        logic [POS_BITS-1:0] position_sample;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] door_angle;
        logic                  busy_res;
        logic [1:0]            door_state;
        logic                  clutch_engaged;
        logic                  motor_dir;
        logic [7:0]            motor_duty;
        logic [11:0]           servo_pulse_us;
    } out_item_t;

    typedef struct packed {
        logic [7:0] open_angle;
        logic [7:0] close_angle;
    } cfg_t;

endpackage

`default_nettype wire

### sv/dcm_cfg.sv
// configuration registers for the open and close angle thresholds
`default_nettype none

module dcm_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [dcm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output dcm_pkg::cfg_t                             cfg
);
    import dcm_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_angle  <= OPEN_ANGLE_RST;
            cfg_reg.close_angle <= CLOSE_ANGLE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OPEN_ANGLE:  cfg_reg.open_angle  <= cfg_data;
                REG_CLOSE_ANGLE: cfg_reg.close_angle <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/dcm_step.sv
// one tick of the sequencer: angle, command checks and the four sequencers
`default_nettype none

module dcm_step #(
    parameter int SAMPLE_BITS = dcm_pkg::SAMPLE_BITS_DEF
) (
    input  dcm_pkg::in_item_t   item,
    input  dcm_pkg::cfg_t       cfg,
    input  dcm_pkg::seq_state_t state_cur,
    output dcm_pkg::seq_state_t state_next,
    output dcm_pkg::out_item_t  result
);
    import dcm_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + 10;

    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS:0]   diff;
    logic [PROD_BITS-1:0]   prod;
    logic [ANGLE_BITS-1:0]  angle;
    logic                   open_reached;
    logic                   close_reached;
    seq_state_t             s;

    // low sample bits only, zero extended when the field is narrower
    assign sample = SAMPLE_BITS'(item.position_sample);
    assign diff   = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, sample};
    assign prod   = PROD_BITS'(diff) * PROD_BITS'(ANGLE_SPAN);
    assign angle  = prod[SAMPLE_BITS +: ANGLE_BITS];

    assign open_reached  = angle >= {1'b0, cfg.open_angle};
    assign close_reached = angle <= {1'b0, cfg.close_angle};

    always_comb
    begin
        s = state_cur;

        if (s.pending == CMD_STARTUP)
        begin
            if (!item.disengaged_switch)
            begin
                s.pending = CMD_DISENGAGE;
            end
            else
            begin
                s.pending = CMD_NONE;
                s.clutch  = 1'b0;
            end
        end
        if (item.mode == MODE_OPEN)
        begin
            s.pending = CMD_OPEN;
        end
        else if (item.mode == MODE_CLOSE)
        begin
            s.pending = CMD_CLOSE;
        end

        // command checks, each may consume the pending command
        if (s.pending == CMD_ENGAGE && !s.clutch)
        begin
            s.engage_phase = CL_START;
            s.pending      = CMD_NONE;
        end
        if (s.pending == CMD_DISENGAGE && s.clutch)
        begin
            s.disengage_phase = CL_START;
            s.pending         = CMD_NONE;
        end
        if (s.pending == CMD_OPEN && !s.busy)
        begin
            s.open_phase = DR_START;
            s.pending    = CMD_NONE;
            s.busy       = 1'b1;
        end
        if (s.pending == CMD_CLOSE && !s.busy)
        begin
            s.close_phase = DR_START;
            s.pending     = CMD_NONE;
            s.busy        = 1'b1;
        end

        // clutch engage
        if (!item.engaged_switch && s.engage_phase == CL_START)
        begin
            s.engage_phase = CL_WAIT;
            s.servo        = SERVO_STOP - SERVO_SWING;
        end
        else if (item.engaged_switch && s.engage_phase == CL_WAIT)
        begin
            s.engage_phase = CL_IDLE;
            s.servo        = SERVO_STOP;
            s.clutch       = 1'b1;
        end

        // clutch disengage
        if (!item.disengaged_switch && s.disengage_phase == CL_START)
        begin
            s.disengage_phase = CL_WAIT;
            s.servo           = SERVO_STOP + SERVO_SWING;
        end
        else if (item.disengaged_switch && s.disengage_phase == CL_WAIT)
        begin
            s.disengage_phase = CL_IDLE;
            s.servo           = SERVO_STOP;
            s.clutch          = 1'b0;
        end

        // open
        if (s.open_phase == DR_START)
        begin
            s.pending    = CMD_ENGAGE;
            s.open_phase = DR_ENGAGE;
            s.duty       = DUTY_STOP - DUTY_SLOW_SET;
            s.dir        = 1'b1;
        end
        else if (s.open_phase == DR_ENGAGE && s.clutch)
        begin
            s.open_phase = DR_DRIVE;
            s.duty       = DUTY_STOP - DUTY_FULL_SET;
            s.dir        = 1'b1;
        end
        else if (open_reached && s.open_phase == DR_DRIVE)
        begin
            s.open_phase = DR_STOP;
            s.duty       = DUTY_STOP;
        end
        else if (s.open_phase == DR_STOP)
        begin
            s.pending    = CMD_DISENGAGE;
            s.open_phase = DR_IDLE;
            s.door       = DOOR_OPENED;
            s.busy       = 1'b0;
        end

        // close
        if (s.close_phase == DR_START)
        begin
            s.pending     = CMD_ENGAGE;
            s.close_phase = DR_ENGAGE;
            s.duty        = DUTY_STOP - DUTY_SLOW_SET;
            s.dir         = 1'b0;
        end
        else if (s.close_phase == DR_ENGAGE && s.clutch)
        begin
            s.close_phase = DR_DRIVE;
            s.duty        = DUTY_STOP - DUTY_FULL_SET;
            s.dir         = 1'b0;
        end
        else if (close_reached && s.close_phase == DR_DRIVE)
        begin
            s.close_phase = DR_STOP;
            s.duty        = DUTY_STOP;
        end
        else if (s.close_phase == DR_STOP)
        begin
            s.pending     = CMD_DISENGAGE;
            s.close_phase = DR_IDLE;
            s.door        = DOOR_CLOSED;
            s.busy        = 1'b0;
        end

        state_next = s;

        result.servo_pulse_us = s.servo;
        result.motor_duty     = s.duty;
        result.motor_dir      = s.dir;
        result.clutch_engaged = s.clutch;
        result.door_state     = s.door;
        result.busy_res       = s.busy;
        result.door_angle     = angle;
    end

endmodule

`default_nettype wire

### sv/door_clutch_motor_sequencer.sv
// top level of the door clutch and motor sequencer
//
// channel   dir  handshake            payload
// s_axis    in   s_tvalid/s_tready    one tick: sample, end switches, command
// m_axis    out  m_tvalid/m_tready    one result: drives, flags, angle
// cfg       in   cfg_valid/cfg_ready  register index and data, always ready
//
// one beat per cycle sustained while m_tready holds; a beat reaches its result through
// the input register, then the tick logic feeding the result register
// the tick logic is one constant multiply for the angle plus the sequencer state updates
// reset clears the sequencer to startup; the first tick resolves the clutch
// a stalled result holds; one further beat waits in the input register
`default_nettype none

module door_clutch_motor_sequencer #(
    parameter int SAMPLE_BITS = dcm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // position_sample[11:0], disengaged_switch[12], engaged_switch[13], mode[15:14]
    input  wire logic [dcm_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // servo_pulse_us[11:0], motor_duty[19:12], motor_dir[20], clutch_engaged[21],
    // door_state[23:22], busy_res[24], door_angle[33:25], zero fill[39:34]
    output logic [dcm_pkg::OUT_DATA_BITS-1:0]        m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [dcm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import dcm_pkg::*;

    cfg_t       cfg;
    in_item_t   in_item_reg;
    logic       in_valid_reg;
    out_item_t  result_reg;
    out_item_t  result_next;
    logic       out_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       advance;

    dcm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcm_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .item       (in_item_reg),
        .cfg        (cfg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS - $bits(out_item_t)){1'b0}}, result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_t'(s_tdata);
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pending         <= CMD_STARTUP;
            state_reg.engage_phase    <= CL_IDLE;
            state_reg.disengage_phase <= CL_IDLE;
            state_reg.open_phase      <= DR_IDLE;
            state_reg.close_phase     <= DR_IDLE;
            state_reg.clutch          <= 1'b1;
            state_reg.door            <= DOOR_UNKNOWN;
            state_reg.busy            <= 1'b0;
            state_reg.servo           <= SERVO_STOP;
            state_reg.duty            <= DUTY_STOP;
            state_reg.dir             <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // busy exactly while a door sequence is running
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.busy == ((state_reg.open_phase != DR_IDLE) ||
                           (state_reg.close_phase != DR_IDLE)))
        else $error("busy flag out of step with door phases");

    // only one door sequence at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        !((state_reg.open_phase != DR_IDLE) && (state_reg.close_phase != DR_IDLE)))
        else $error("open and close sequences overlap");

    // state moves only when a tick is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a tick");

    // an empty result stage never holds off the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result stage");

endmodule

`default_nettype wire
